[src/brs_pkg.sv]
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types and constants of the bidirectional rungler sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package brs_pkg;

  // Ring geometry
  localparam int unsigned CELL_COUNT = 6;

  // Switch codes; the fourth code behaves as the middle position
  localparam logic [1:0] SW_DOWN   = 2'd0;
  localparam logic [1:0] SW_MIDDLE = 2'd1;
  localparam logic [1:0] SW_UP     = 2'd2;

  // Bits of the jack mask register
  localparam int unsigned MASK_AUDIO_A = 0;
  localparam int unsigned MASK_AUDIO_B = 1;
  localparam int unsigned MASK_CV_A    = 2;
  localparam int unsigned MASK_CV_B    = 3;
  localparam int unsigned MASK_W       = 4;

  // Random generator
  localparam logic [31:0] LCG_MUL   = 32'd1664525;
  localparam logic [31:0] LCG_INC   = 32'd1013904223;
  localparam logic [31:0] SEED_INIT = 32'd1;

  // Threshold limits
  localparam logic [11:0] THR_LOW  = 12'd15;
  localparam logic [11:0] THR_HIGH = 12'(4095 - 15);
  localparam logic [11:0] THR_FULL = 12'd4095;

  localparam logic [1:0] CELL_SET   = 2'h3;
  localparam logic [1:0] CELL_CLEAR = 2'h0;
  localparam int         MIDSCALE   = 2048;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,
    ST_BACK,
    ST_GAIN,
    ST_LVA,
    ST_LVB,
    ST_DONE
  } brs_state_e;

  typedef enum logic [1:0] {
    MUL_OFFSET,
    MUL_GAIN,
    MUL_LEVEL_A,
    MUL_LEVEL_B
  } mul_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     fwd_step;
    logic     back_step;
    logic     off_load;
    logic     gain_load;
    mul_sel_e mul_sel;
    logic     prod_load;
    logic     lva_load;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

[src/brs_ctrl.sv]
// ----------------------------------------------------------------------------
// brs_ctrl
// Sequencer for one transaction: ring steps, hold resampling, level products.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire brs_pkg::dp_status_t status_i,
  output brs_pkg::dp_cmd_t         cmd_o
);

  brs_pkg::brs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      brs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = brs_pkg::ST_FWD;
        end
      end
      brs_pkg::ST_FWD:  state_d = brs_pkg::ST_BACK;
      brs_pkg::ST_BACK: state_d = brs_pkg::ST_GAIN;
      brs_pkg::ST_GAIN: state_d = brs_pkg::ST_LVA;
      brs_pkg::ST_LVA:  state_d = brs_pkg::ST_LVB;
      brs_pkg::ST_LVB:  state_d = brs_pkg::ST_DONE;
      brs_pkg::ST_DONE: begin
        if (!status_i.out_busy) begin
          state_d = brs_pkg::ST_IDLE;
        end
      end
      default: state_d = brs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.mul_sel   = brs_pkg::MUL_OFFSET;
    unique case (state_q)
      brs_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      brs_pkg::ST_FWD: begin
        cmd_o.fwd_step  = 1'b1;
        cmd_o.mul_sel   = brs_pkg::MUL_OFFSET;
        cmd_o.prod_load = 1'b1;
      end
      brs_pkg::ST_BACK: begin
        // offset product is ready; start the gain product
        cmd_o.back_step = 1'b1;
        cmd_o.off_load  = 1'b1;
        cmd_o.mul_sel   = brs_pkg::MUL_GAIN;
        cmd_o.prod_load = 1'b1;
      end
      brs_pkg::ST_GAIN: begin
        cmd_o.gain_load = 1'b1;
      end
      brs_pkg::ST_LVA: begin
        cmd_o.mul_sel   = brs_pkg::MUL_LEVEL_A;
        cmd_o.prod_load = 1'b1;
      end
      brs_pkg::ST_LVB: begin
        cmd_o.lva_load  = 1'b1;
        cmd_o.mul_sel   = brs_pkg::MUL_LEVEL_B;
        cmd_o.prod_load = 1'b1;
      end
      brs_pkg::ST_DONE: begin
        cmd_o.out_load = !status_i.out_busy;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == brs_pkg::ST_FWD))
    else $error("accepted transaction did not start the forward step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !status_i.out_busy)
    else $error("result loaded over a pending result");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == brs_pkg::ST_DONE && status_i.out_busy) |=> (state_q == brs_pkg::ST_DONE))
    else $error("left the done state while the output was stalled");

  a_level_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == brs_pkg::ST_LVB) |=> (state_q == brs_pkg::ST_DONE))
    else $error("level b product not followed by result stage");

endmodule

`default_nettype wire

[src/brs_datapath.sv]
// ----------------------------------------------------------------------------
// brs_datapath
// Ring, random generator, held offset/gain, shared multiplier, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_datapath #(
  parameter int unsigned CellCount = brs_pkg::CELL_COUNT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [brs_pkg::MASK_W-1:0]     cfg_wdata_i,
  input  wire logic                           fwd_edge_i,
  input  wire logic                           back_edge_i,
  input  wire logic [1:0]                     switch_pos_i,
  input  wire logic [11:0]                    main_knob_i,
  input  wire logic signed [11:0]             audio_in_a_i,
  input  wire logic signed [11:0]             audio_in_b_i,
  input  wire logic [11:0]                    knob_offset_i,
  input  wire logic [11:0]                    knob_gain_i,
  input  wire logic signed [11:0]             cv_in_a_i,
  input  wire logic signed [11:0]             cv_in_b_i,
  input  wire brs_pkg::dp_cmd_t               cmd_i,
  output brs_pkg::dp_status_t                 status_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [11:0]                  voice_out_a_o,
  output logic signed [11:0]                  voice_out_b_o,
  output logic signed [11:0]                  level_a_o,
  output logic signed [11:0]                  level_b_o,
  output logic                                gate_a_o,
  output logic                                gate_b_o
);

  function automatic logic signed [11:0] clip12(input logic signed [14:0] v);
    logic signed [11:0] r;
    if (v < -15'sd2048) begin
      r = 12'sh800;
    end else if (v > 15'sd2047) begin
      r = 12'sh7FF;
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

  // Configuration
  logic [brs_pkg::MASK_W-1:0] mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

  // Captured transaction
  logic               fwd_q, back_q;
  logic [1:0]         sw_q;
  logic [11:0]        knob_q, koff_q, kgain_q;
  logic signed [11:0] aud_a_q, aud_b_q, cv_a_q, cv_b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      fwd_q   <= fwd_edge_i;
      back_q  <= back_edge_i;
      sw_q    <= switch_pos_i;
      knob_q  <= main_knob_i;
      aud_a_q <= audio_in_a_i;
      aud_b_q <= audio_in_b_i;
      koff_q  <= knob_offset_i;
      kgain_q <= knob_gain_i;
      cv_a_q  <= cv_in_a_i;
      cv_b_q  <= cv_in_b_i;
    end
  end

  // Threshold
  logic [11:0] thr_raw, thr;
  logic        stable;

  always_comb begin
    if (mask_q[brs_pkg::MASK_AUDIO_B]) begin
      // clip below zero, then double
      thr_raw = aud_b_q[11] ? 12'd0 : {aud_b_q[10:0], 1'b0};
    end else begin
      thr_raw = knob_q;
    end
    stable = (thr_raw < brs_pkg::THR_LOW);
    if (stable) begin
      thr = '0;
    end else if (thr_raw > brs_pkg::THR_HIGH) begin
      thr = brs_pkg::THR_FULL;
    end else begin
      thr = thr_raw;
    end
  end

  // Random or external data
  logic [31:0] seed_q, seed_d, seed_next;
  logic [11:0] data, bdata;
  logic        use_ext, toggle_mode, random_mode;

  assign seed_next   = seed_q * brs_pkg::LCG_MUL + brs_pkg::LCG_INC;
  assign use_ext     = mask_q[brs_pkg::MASK_AUDIO_A];
  assign data        = use_ext ? {~aud_a_q[11], aud_a_q[10:0]} : seed_next[31:20];
  assign bdata       = (data == 12'd0) ? 12'd1 :
                       (data == 12'hFFF) ? 12'hFFE : data;
  assign toggle_mode = (sw_q == brs_pkg::SW_UP) || stable;
  assign random_mode = (sw_q != brs_pkg::SW_DOWN) && !toggle_mode;

  // Ring
  logic [1:0] cells_q [CellCount];
  logic [1:0] cells_d [CellCount];
  logic [1:0] new_fwd, new_back, last_cell, first_cell;
  logic       fwd_go, back_go;

  assign last_cell  = cells_q[CellCount-1];
  assign first_cell = cells_q[0];
  assign fwd_go     = cmd_i.fwd_step && fwd_q;
  assign back_go    = cmd_i.back_step && back_q;

  always_comb begin
    if (sw_q == brs_pkg::SW_DOWN) begin
      new_fwd = brs_pkg::CELL_SET;
    end else if (toggle_mode) begin
      new_fwd = ~last_cell;
    end else if (data > thr) begin
      new_fwd = ~data[1:0];
    end else begin
      new_fwd = last_cell;
    end

    if (sw_q == brs_pkg::SW_DOWN) begin
      new_back = brs_pkg::CELL_CLEAR;
    end else if (toggle_mode) begin
      new_back = ~first_cell;
    end else if (bdata > thr) begin
      new_back = ~bdata[1:0];
    end else begin
      new_back = first_cell;
    end
  end

  always_comb begin
    cells_d = cells_q;
    if (fwd_go) begin
      for (int i = 1; i < CellCount; i++) begin
        cells_d[i] = cells_q[i-1];
      end
      cells_d[0] = new_fwd;
    end else if (back_go) begin
      for (int i = 0; i < CellCount - 1; i++) begin
        cells_d[i] = cells_q[i+1];
      end
      cells_d[CellCount-1] = new_back;
    end
  end

  // advance the generator only when its draw is consumed
  assign seed_d = ((fwd_go || back_go) && random_mode && !use_ext) ? seed_next : seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CellCount; i++) begin
        cells_q[i] <= '0;
      end
      seed_q <= brs_pkg::SEED_INIT;
    end else begin
      cells_q <= cells_d;
      seed_q  <= seed_d;
    end
  end

  // Shared multiplier
  logic [5:0]         raw_a, raw_b;
  logic [12:0]        off_q, gain_q;
  logic signed [12:0] mul_a;
  logic signed [13:0] mul_b;
  logic signed [26:0] prod_d, prod_q;

  assign raw_a = {cells_q[2], cells_q[1], cells_q[0]};
  assign raw_b = {cells_q[CellCount-1], cells_q[CellCount-2], cells_q[CellCount-3]};

  always_comb begin
    unique case (cmd_i.mul_sel)
      brs_pkg::MUL_OFFSET: begin
        mul_a = {cv_a_q[11], cv_a_q};
        mul_b = $signed({2'b00, koff_q}) - 14'sd2048;
      end
      brs_pkg::MUL_GAIN: begin
        mul_a = {cv_b_q[11], cv_b_q};
        mul_b = $signed({2'b00, kgain_q});
      end
      brs_pkg::MUL_LEVEL_A: begin
        mul_a = $signed({7'b0, raw_a});
        mul_b = $signed({1'b0, gain_q});
      end
      brs_pkg::MUL_LEVEL_B: begin
        mul_a = $signed({7'b0, raw_b});
        mul_b = $signed({1'b0, gain_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_load) begin
      prod_q <= prod_d;
    end
  end

  // Hold resampling
  logic signed [14:0] prod_sh, off_sum;
  logic [12:0]        off_new, gain_new;
  logic [11:0]        gain_clip;
  logic               any_edge;

  assign prod_sh  = $signed(prod_q[26:12]);
  assign off_sum  = prod_sh + 15'sd2048;
  assign off_new  = off_sum[12:0];
  assign any_edge = fwd_q || back_q;

  always_comb begin
    if (prod_sh < 15'sd0) begin
      gain_clip = '0;
    end else if (prod_sh > 15'sd2048) begin
      gain_clip = 12'd2048;
    end else begin
      gain_clip = prod_sh[11:0];
    end
    gain_new = {gain_clip, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= '0;
      gain_q <= '0;
    end else begin
      if (cmd_i.off_load && any_edge) begin
        off_q <= mask_q[brs_pkg::MASK_CV_A] ? off_new : {1'b0, koff_q};
      end
      if (cmd_i.gain_load && any_edge) begin
        gain_q <= mask_q[brs_pkg::MASK_CV_B] ? gain_new : {1'b0, kgain_q};
      end
    end
  end

  // Level: raw is the 6-bit word shifted up by 6, so (raw * gain) >> 12 = product >> 6
  logic signed [14:0] lvl_x, lvl_neg;
  logic signed [11:0] lva_q, vca_q;

  assign lvl_x   = $signed({3'b000, prod_q[17:6]}) + $signed({2'b00, off_q})
                   - 15'sd2048;
  assign lvl_neg = -lvl_x;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lva_load) begin
      lva_q <= clip12(lvl_x);
      vca_q <= clip12(lvl_neg);
    end
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      level_a_o     <= lva_q;
      voice_out_a_o <= vca_q;
      level_b_o     <= clip12(lvl_x);
      voice_out_b_o <= clip12(lvl_neg);
      gate_a_o      <= cells_q[CellCount-4][0];
      gate_b_o      <= cells_q[CellCount-1][0];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

endmodule

`default_nettype wire

[src/bidirectional_rungler_sequencer.sv]
// ----------------------------------------------------------------------------
// bidirectional_rungler_sequencer
// Bidirectional looping shift-register sequencer with a random source.
// ----------------------------------------------------------------------------
// Usage:
//   One input transaction per audio sample on in_valid_i/in_ready_o carries
//   the clock edges, switch, knobs, audio and CV samples. Each transaction
//   gives exactly one result on out_valid_o/out_ready_i: two inverted levels,
//   two uninverted levels and two gates.
//   The result is loaded into the output register after the forward step,
//   back step, gain, level A and level B states. A new transaction is taken
//   only once the last result is loaded; the ring steps, hold updates and
//   level products share one 13x14 multiplier and run one at a time.
//   The output register frees the datapath: while a result waits, the next
//   transaction is still accepted and processed, and only its final load
//   waits until the receiver takes the pending result.
//   cfg_we_i writes the jack mask at once; write it only while idle.
//   Reset clears the ring, holds and mask, sets the seed to one, and drops
//   any pending result. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module bidirectional_rungler_sequencer #(
  parameter int unsigned CellCount = brs_pkg::CELL_COUNT
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [brs_pkg::MASK_W-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       fwd_edge_i,
  input  wire logic                       back_edge_i,
  input  wire logic [1:0]                 switch_pos_i,
  input  wire logic [11:0]                main_knob_i,
  input  wire logic signed [11:0]         audio_in_a_i,
  input  wire logic signed [11:0]         audio_in_b_i,
  input  wire logic [11:0]                knob_offset_i,
  input  wire logic [11:0]                knob_gain_i,
  input  wire logic signed [11:0]         cv_in_a_i,
  input  wire logic signed [11:0]         cv_in_b_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [11:0]              voice_out_a_o,
  output logic signed [11:0]              voice_out_b_o,
  output logic signed [11:0]              level_a_o,
  output logic signed [11:0]              level_b_o,
  output logic                            gate_a_o,
  output logic                            gate_b_o
);

  brs_pkg::dp_cmd_t    cmd;
  brs_pkg::dp_status_t status;

  brs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  brs_datapath #(
    .CellCount (CellCount)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fwd_edge_i    (fwd_edge_i),
    .back_edge_i   (back_edge_i),
    .switch_pos_i  (switch_pos_i),
    .main_knob_i   (main_knob_i),
    .audio_in_a_i  (audio_in_a_i),
    .audio_in_b_i  (audio_in_b_i),
    .knob_offset_i (knob_offset_i),
    .knob_gain_i   (knob_gain_i),
    .cv_in_a_i     (cv_in_a_i),
    .cv_in_b_i     (cv_in_b_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .voice_out_a_o (voice_out_a_o),
    .voice_out_b_o (voice_out_b_o),
    .level_a_o     (level_a_o),
    .level_b_o     (level_b_o),
    .gate_a_o      (gate_a_o),
    .gate_b_o      (gate_b_o)
  );

endmodule

`default_nettype wire
